FILE: rtl/frsp_pkg.sv
// Shared types and constants for the filter rule string parser.
// Holds the parser state record, the result record and the character codes.
// No dependencies.
package frsp_pkg;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_UP_I  = 8'h49;
   localparam logic [7:0] CH_UP_O  = 8'h4F;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_LO_P  = 8'h70;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_S  = 8'h73;

   localparam logic [19:0] U8_MAX  = 20'd255;
   localparam logic [19:0] U16_MAX = 20'd65535;

   localparam logic [1:0] LAST_OCTET = 2'd3;

   localparam int RSP_WIDTH = 112;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_SIGN  = 3'd2,
      PH_TYPE0 = 3'd3,
      PH_TYPE1 = 3'd4,
      PH_NUM   = 3'd5,
      PH_ADDR  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      K_PR = 3'd0,
      K_SP = 3'd1,
      K_DP = 3'd2,
      K_SA = 3'd3,
      K_DA = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  list_code;
      logic        failed;
      logic        term_sign;
      kind_type    term_kind;
      logic [15:0] digit_value;
      logic        seen_digit;
      logic [1:0]  octet_index;
      logic [23:0] address_value;
      logic [4:0]  mask_bits;
      logic [7:0]  proto_held;
      logic [15:0] sport_held;
      logic [15:0] dport_held;
      logic [31:0] saddr_held;
      logic [31:0] daddr_held;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase: PH_HDR0, list_code: 2'd0, failed: 1'b0, term_sign: 1'b0,
      term_kind: K_PR, digit_value: 16'd0, seen_digit: 1'b0, octet_index: 2'd0,
      address_value: 24'd0, mask_bits: 5'd0, proto_held: 8'd0, sport_held: 16'd0,
      dport_held: 16'd0, saddr_held: 32'd0, daddr_held: 32'd0};

   typedef struct packed {
      logic [31:0] dst_addr;
      logic [31:0] src_addr;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [7:0]  proto_value;
      logic [4:0]  include_mask;
      logic [1:0]  list_select;
      logic        valid_res;
   } rsp_type;

endpackage

FILE: rtl/frsp_step.sv
// One character step of the rule parser, purely combinational.
// Gives the next parser state and the result the string would have if it ended here.
// Depends on frsp_pkg.
module frsp_step (
   input  frsp_pkg::parse_state_type cur,
   input  logic [7:0]                ch,
   output frsp_pkg::parse_state_type nxt,
   output frsp_pkg::rsp_type         res
);
   import frsp_pkg::*;

   logic            is_digit;
   logic [19:0]     acc;
   logic [19:0]     limit;
   logic [31:0]     full_addr;
   logic [31:0]     fin_addr;
   logic            num_ok;
   logic            addr_ok;
   logic            ok;
   parse_state_type s;
   parse_state_type f;

   assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
   assign acc   = {1'b0, cur.digit_value, 3'b000} + {3'b000, cur.digit_value, 1'b0}
                + {16'd0, ch[3:0]};
   assign limit = (cur.phase == PH_ADDR || cur.term_kind == K_PR) ? U8_MAX : U16_MAX;
   assign full_addr = {cur.address_value, cur.digit_value[7:0]};

   // Sign character that opens a term; anything else is an error.
   function automatic parse_state_type begin_term(parse_state_type p, logic [7:0] c);
      parse_state_type q;
      q = p;
      if (c == CH_PLUS) begin
         q.term_sign = 1'b1;
         q.phase     = PH_TYPE0;
      end else if (c == CH_MINUS) begin
         q.term_sign = 1'b0;
         q.phase     = PH_TYPE0;
      end else begin
         q.failed = 1'b1;
      end
      return q;
   endfunction

   // Store a finished port or protocol value.
   function automatic parse_state_type store_num(parse_state_type p);
      parse_state_type q;
      q = p;
      case (p.term_kind)
         K_PR: begin
            q.proto_held   = p.digit_value[7:0];
            q.mask_bits[0] = p.mask_bits[0] | p.term_sign;
         end
         K_SP: begin
            q.sport_held   = p.digit_value;
            q.mask_bits[3] = p.mask_bits[3] | p.term_sign;
         end
         default: begin
            q.dport_held   = p.digit_value;
            q.mask_bits[4] = p.mask_bits[4] | p.term_sign;
         end
      endcase
      return q;
   endfunction

   // Store a finished address whose fourth octet is still in the digit register.
   function automatic parse_state_type store_addr(parse_state_type p, logic [31:0] a);
      parse_state_type q;
      q = p;
      if (p.term_kind == K_SA) begin
         q.saddr_held   = a;
         q.mask_bits[1] = p.mask_bits[1] | p.term_sign;
      end else begin
         q.daddr_held   = a;
         q.mask_bits[2] = p.mask_bits[2] | p.term_sign;
      end
      return q;
   endfunction

   always_comb begin
      s = cur;
      if (!cur.failed) begin
         case (cur.phase)
            PH_HDR0: begin
               if (ch == CH_UP_A) begin
                  s.list_code = 2'd0;
                  s.phase     = PH_HDR1;
               end else if (ch == CH_UP_D) begin
                  s.list_code = 2'd2;
                  s.phase     = PH_HDR1;
               end else begin
                  s.failed = 1'b1;
               end
            end
            PH_HDR1: begin
               if (ch == CH_UP_I) begin
                  s.phase = PH_SIGN;
               end else if (ch == CH_UP_O) begin
                  s.list_code[0] = 1'b1;
                  s.phase        = PH_SIGN;
               end else begin
                  s.failed = 1'b1;
               end
            end
            PH_SIGN: begin
               s = begin_term(cur, ch);
            end
            PH_TYPE0: begin
               if (ch == CH_LO_P) begin
                  s.term_kind = K_PR;
                  s.phase     = PH_TYPE1;
               end else if (ch == CH_LO_S) begin
                  s.term_kind = K_SP;
                  s.phase     = PH_TYPE1;
               end else if (ch == CH_LO_D) begin
                  s.term_kind = K_DP;
                  s.phase     = PH_TYPE1;
               end else begin
                  s.failed = 1'b1;
               end
            end
            PH_TYPE1: begin
               s.digit_value   = 16'd0;
               s.seen_digit    = 1'b0;
               s.octet_index   = 2'd0;
               s.address_value = 24'd0;
               if (cur.term_kind == K_PR && ch == CH_LO_R) begin
                  s.phase = PH_NUM;
               end else if (cur.term_kind != K_PR && ch == CH_LO_P) begin
                  s.phase = PH_NUM;
               end else if (cur.term_kind != K_PR && ch == CH_LO_A) begin
                  // Source or destination port kind turns into the address kind.
                  s.term_kind = (cur.term_kind == K_SP) ? K_SA : K_DA;
                  s.phase     = PH_ADDR;
               end else begin
                  s.failed = 1'b1;
               end
            end
            PH_NUM, PH_ADDR: begin
               if (is_digit) begin
                  s.digit_value = acc[15:0];
                  s.seen_digit  = 1'b1;
                  if (acc > limit) begin
                     s.failed = 1'b1;
                  end
               end else if (cur.phase == PH_NUM) begin
                  if (!cur.seen_digit || cur.digit_value == 16'd0) begin
                     s.failed = 1'b1;
                  end else begin
                     s = begin_term(store_num(cur), ch);
                  end
               end else if (cur.octet_index != LAST_OCTET) begin
                  if (!cur.seen_digit) begin
                     s.failed = 1'b1;
                  end else begin
                     s.address_value = {cur.address_value[15:0], cur.digit_value[7:0]};
                     s.octet_index   = cur.octet_index + 2'd1;
                     s.digit_value   = 16'd0;
                     s.seen_digit    = 1'b0;
                  end
               end else begin
                  if (!cur.seen_digit || full_addr == 32'd0) begin
                     s.failed = 1'b1;
                  end else begin
                     s = begin_term(store_addr(cur, full_addr), ch);
                  end
               end
            end
            default: begin
               s.failed = 1'b1;
            end
         endcase
      end
   end

   assign nxt = s;

   // Closing checks for a string that ends on this character.
   assign fin_addr = {s.address_value, s.digit_value[7:0]};
   assign num_ok   = s.seen_digit && s.digit_value != 16'd0;
   assign addr_ok  = s.seen_digit && fin_addr != 32'd0 && s.octet_index == LAST_OCTET;

   always_comb begin
      f  = s;
      ok = 1'b0;
      if (!s.failed) begin
         case (s.phase)
            PH_SIGN: begin
               ok = 1'b1;
            end
            PH_NUM: begin
               ok = num_ok;
               f  = store_num(s);
            end
            PH_ADDR: begin
               ok = addr_ok;
               f  = store_addr(s, fin_addr);
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
      res = '0;
      if (ok) begin
         res.valid_res    = 1'b1;
         res.list_select  = f.list_code;
         res.include_mask = f.mask_bits;
         res.proto_value  = f.proto_held;
         res.src_port     = f.sport_held;
         res.dst_port     = f.dport_held;
         res.src_addr     = f.saddr_held;
         res.dst_addr     = f.daddr_held;
      end
   end

endmodule

FILE: rtl/filter_rule_string_parser_unit.sv
// Top level of the filter rule string parser.
// Input register, parser state register and result register around frsp_step.
// Depends on frsp_pkg and frsp_step.
//
//   channel | ports       | tdata fields (low bit up)                          | tlast
//   --------+-------------+----------------------------------------------------+------------
//   request | req_t*      | ch[7:0]                                            | last char
//   result  | rsp_t*      | valid_res, list_select, include_mask, proto_value, | not used
//           |             | src_port, dst_port, src_addr, dst_addr (112 bits)  |
//
// The block takes one character word in every cycle while no last character waits for room in
// the result register. Each character sits in the input register, where a single pass of the
// step logic updates the parser state; that state loop is what sets the rate of one character
// per clock. A result word is loaded into the result register at the edge where the last
// character leaves the input register.
// Reset clears the input register, the parser state and the result valid flag at once.
// A stalled result blocks only a last character behind it; other characters keep flowing.
module filter_rule_string_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ch[7:0]
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // valid_res[0], list_select[2:1], include_mask[7:3], proto_value[15:8],
   // src_port[31:16], dst_port[47:32], src_addr[79:48], dst_addr[111:80]
   output logic [frsp_pkg::RSP_WIDTH-1:0]      rsp_tdata
);
   import frsp_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_ch_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_next;
   rsp_type         step_res;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_type         out_data_ff;
   logic            advance;
   logic            out_free;

   frsp_step u_step (
      .cur (state_ff),
      .ch  (in_ch_ff),
      .nxt (state_next),
      .res (step_res)
   );

   // A character that ends a string needs room in the result register.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? PARSE_RESET : state_next;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= PARSE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_data_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for filter_rule_string_parser_unit.
// Streams rule strings one character word at a time and checks each result word against a
// cycle-free model of the parser kept in this file. Depends on frsp_pkg and the RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frsp_pkg::*;

   // Longest receiver hold-off during the input stall test, and the watchdog limit on cycles
   // in which neither side moves a word. The limit sits well above the hold-off.
   localparam int LONG_HOLD    = 200;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 910;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'd0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   filter_rule_string_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Parsed rules the block still owes us, oldest first.
   rsp_type    expected_rules[$];
   // Characters of the rule string being assembled for sending.
   logic [7:0] rule_chars[$];

   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  sender_gaps_on = 1'b1;
   bit  receiver_gaps_on = 1'b1;
   bit  long_hold_req = 1'b0;

   // Parser model state. Digits are accumulated at 32 bits so an overflow is seen before any
   // truncation; the string is marked bad at the first digit that passes the limit.
   phase_type   rule_phase;
   logic [1:0]  rule_list;
   logic        rule_failed;
   logic        rule_plus;
   kind_type    rule_kind;
   logic [31:0] rule_digits;
   logic        rule_have_digit;
   logic [1:0]  rule_octet;
   logic [31:0] rule_addr;
   logic [4:0]  rule_mask;
   logic [7:0]  held_proto;
   logic [15:0] held_sport;
   logic [15:0] held_dport;
   logic [31:0] held_saddr;
   logic [31:0] held_daddr;

   function automatic void clear_rule();
      rule_phase      = PH_HDR0;
      rule_list       = 2'd0;
      rule_failed     = 1'b0;
      rule_plus       = 1'b0;
      rule_kind       = K_PR;
      rule_digits     = 32'd0;
      rule_have_digit = 1'b0;
      rule_octet      = 2'd0;
      rule_addr       = 32'd0;
      rule_mask       = 5'd0;
      held_proto      = 8'd0;
      held_sport      = 16'd0;
      held_dport      = 16'd0;
      held_saddr      = 32'd0;
      held_daddr      = 32'd0;
   endfunction

   // Commits a protocol or port term. A missing or zero value is an error.
   function automatic bit store_number();
      if (!rule_have_digit || rule_digits == 32'd0) return 1'b0;
      case (rule_kind)
         K_PR: begin
            held_proto   = rule_digits[7:0];
            rule_mask[0] = rule_mask[0] | rule_plus;
         end
         K_SP: begin
            held_sport   = rule_digits[15:0];
            rule_mask[3] = rule_mask[3] | rule_plus;
         end
         default: begin
            held_dport   = rule_digits[15:0];
            rule_mask[4] = rule_mask[4] | rule_plus;
         end
      endcase
      return 1'b1;
   endfunction

   // Commits an address term; the fourth octet is still in the digit accumulator.
   function automatic bit store_address();
      logic [31:0] full;
      if (!rule_have_digit) return 1'b0;
      full = {rule_addr[23:0], rule_digits[7:0]};
      if (full == 32'd0) return 1'b0;
      if (rule_kind == K_SA) begin
         held_saddr   = full;
         rule_mask[1] = rule_mask[1] | rule_plus;
      end else begin
         held_daddr   = full;
         rule_mask[2] = rule_mask[2] | rule_plus;
      end
      return 1'b1;
   endfunction

   function automatic void open_term(input logic [7:0] c);
      if (c == CH_PLUS) rule_plus = 1'b1;
      else if (c == CH_MINUS) rule_plus = 1'b0;
      else begin
         rule_failed = 1'b1;
         return;
      end
      rule_phase = PH_TYPE0;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      logic [31:0] limit;
      logic        is_digit;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (rule_phase)
         PH_HDR0: begin
            if (c == CH_UP_A) rule_list = 2'd0;
            else if (c == CH_UP_D) rule_list = 2'd2;
            else begin
               rule_failed = 1'b1;
               return;
            end
            rule_phase = PH_HDR1;
         end
         PH_HDR1: begin
            if (c == CH_UP_O) rule_list[0] = 1'b1;
            else if (c != CH_UP_I) begin
               rule_failed = 1'b1;
               return;
            end
            rule_phase = PH_SIGN;
         end
         PH_SIGN: open_term(c);
         PH_TYPE0: begin
            if (c == CH_LO_P) rule_kind = K_PR;
            else if (c == CH_LO_S) rule_kind = K_SP;
            else if (c == CH_LO_D) rule_kind = K_DP;
            else begin
               rule_failed = 1'b1;
               return;
            end
            rule_phase = PH_TYPE1;
         end
         PH_TYPE1: begin
            rule_digits     = 32'd0;
            rule_have_digit = 1'b0;
            rule_octet      = 2'd0;
            rule_addr       = 32'd0;
            if (rule_kind == K_PR && c == CH_LO_R) rule_phase = PH_NUM;
            else if (rule_kind != K_PR && c == CH_LO_P) rule_phase = PH_NUM;
            else if (rule_kind != K_PR && c == CH_LO_A) begin
               if (rule_kind == K_SP) rule_kind = K_SA;
               else rule_kind = K_DA;
               rule_phase = PH_ADDR;
            end else rule_failed = 1'b1;
         end
         PH_NUM, PH_ADDR: begin
            if (is_digit) begin
               limit = (rule_phase == PH_ADDR || rule_kind == K_PR) ? 32'd255 : 32'd65535;
               rule_digits     = rule_digits * 10 + {24'd0, c - CH_ZERO};
               rule_have_digit = 1'b1;
               if (rule_digits > limit) rule_failed = 1'b1;
            end else if (rule_phase == PH_NUM) begin
               if (!store_number()) begin
                  rule_failed = 1'b1;
                  return;
               end
               rule_phase = PH_SIGN;
               open_term(c);
            end else if (rule_octet < LAST_OCTET) begin
               // Any one non-digit closes an inner octet.
               if (!rule_have_digit) begin
                  rule_failed = 1'b1;
                  return;
               end
               rule_addr       = {rule_addr[23:0], rule_digits[7:0]};
               rule_octet      = rule_octet + 2'd1;
               rule_digits     = 32'd0;
               rule_have_digit = 1'b0;
            end else begin
               if (!store_address()) begin
                  rule_failed = 1'b1;
                  return;
               end
               rule_phase = PH_SIGN;
               open_term(c);
            end
         end
         default: rule_failed = 1'b1;
      endcase
   endfunction

   // Advances the model by one accepted word and queues the result a last character causes.
   function automatic void predict_word(input logic [7:0] c, input logic fin);
      rsp_type want;
      logic    ok;
      if (!rule_failed) parse_char(c);
      if (!fin) return;
      ok = !rule_failed;
      if (ok) begin
         case (rule_phase)
            PH_SIGN: ok = 1'b1;
            PH_NUM:  ok = store_number();
            PH_ADDR: ok = (rule_octet == LAST_OCTET) ? store_address() : 1'b0;
            default: ok = 1'b0;
         endcase
      end
      want = '0;
      if (ok) begin
         want.valid_res    = 1'b1;
         want.list_select  = rule_list;
         want.include_mask = rule_mask;
         want.proto_value  = held_proto;
         want.src_port     = held_sport;
         want.dst_port     = held_dport;
         want.src_addr     = held_saddr;
         want.dst_addr     = held_daddr;
      end
      expected_rules.push_back(want);
      clear_rule();
   endfunction

   initial clear_rule();

   // The model follows every word the block accepts.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) predict_word(req_tdata, req_tlast);
   end

   task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Every accepted result word is matched against the oldest expected rule.
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rules.size() == 0) begin
            $error("result word arrived with no rule pending");
            error_count++;
         end else begin
            want = expected_rules.pop_front();
            compare_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
            compare_field("list_select", 32'(want.list_select), 32'(got.list_select));
            compare_field("include_mask", 32'(want.include_mask), 32'(got.include_mask));
            compare_field("proto_value", 32'(want.proto_value), 32'(got.proto_value));
            compare_field("src_port", 32'(want.src_port), 32'(got.src_port));
            compare_field("dst_port", 32'(want.dst_port), 32'(got.dst_port));
            compare_field("src_addr", want.src_addr, got.src_addr);
            compare_field("dst_addr", want.dst_addr, got.dst_addr);
         end
      end
   end

   // Ends the run if the two channels stay quiet for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: a random pause before each word, or one long hold-off when asked for.
   initial begin : result_receiver
      int hold;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            hold = receiver_gaps_on ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
               rsp_tready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Offers one character word and returns at the edge that accepts it.
   task automatic send_word(input logic [7:0] c, input logic fin);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_rule();
      int i;
      for (i = 0; i < rule_chars.size(); i++) send_word(rule_chars[i], i == rule_chars.size() - 1);
      rule_chars.delete();
   endtask

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) rule_chars.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      put_text(s);
      send_rule();
   endtask

   function automatic logic [7:0] any_non_digit();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
      return b;
   endfunction

   // Decimal value for a protocol or port term, mostly in range with the edges favored.
   task automatic put_value(input int limit);
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 3) return;
      if (pick < 13) v = limit;
      else if (pick < 23) v = 1;
      else if (pick < 27) v = 0;
      else if (pick < 31) v = limit + 1 + $urandom_range(0, limit * 3);
      else v = $urandom_range(1, limit);
      if ($urandom_range(0, 9) == 0) put_text("00");
      put_text($sformatf("%0d", v));
   endtask

   task automatic put_address();
      int i;
      int pick;
      bit all_zero;
      all_zero = ($urandom_range(0, 29) == 0);
      for (i = 0; i < 4; i++) begin
         pick = $urandom_range(0, 99);
         if (all_zero) put_text("0");
         else if (pick < 8) put_text("255");
         else if (pick < 16) put_text("0");
         else if (pick < 18) put_text($sformatf("%0d", $urandom_range(256, 999)));
         else if (pick < 19) begin
            // No digits in this octet.
         end else begin
            if (pick < 24) put_text("0");
            put_text($sformatf("%0d", $urandom_range(0, 255)));
         end
         if (i < 3) begin
            if ($urandom_range(0, 3) != 0) put_text(".");
            else rule_chars.push_back(any_non_digit());
         end
      end
   endtask

   task automatic put_random_term();
      if ($urandom_range(0, 49) == 0) rule_chars.push_back(8'($urandom_range(0, 255)));
      else rule_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      case ($urandom_range(0, 4))
         0: begin put_text("pr"); put_value(255); end
         1: begin put_text("sp"); put_value(65535); end
         2: begin put_text("dp"); put_value(65535); end
         3: begin put_text("sa"); put_address(); end
         default: begin put_text("da"); put_address(); end
      endcase
   endtask

   // Mostly well-formed rules with random content; a share are damaged or pure noise.
   task automatic build_random_rule();
      int pick;
      int pos;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 4) rule_chars.push_back(8'($urandom_range(0, 255)));
      else rule_chars.push_back($urandom_range(0, 1) ? CH_UP_A : CH_UP_D);
      pick = $urandom_range(0, 99);
      if (pick < 4) rule_chars.push_back(8'($urandom_range(0, 255)));
      else rule_chars.push_back($urandom_range(0, 1) ? CH_UP_I : CH_UP_O);
      repeat ($urandom_range(0, 3)) put_random_term();
      pick = $urandom_range(0, 99);
      pos  = $urandom_range(0, rule_chars.size() - 1);
      if (pick < 8) rule_chars[pos] = 8'($urandom_range(0, 255));
      else if (pick < 14) begin
         n = $urandom_range(1, rule_chars.size());
         while (rule_chars.size() > n) void'(rule_chars.pop_back());
      end else if (pick < 18) rule_chars.insert(pos, 8'($urandom_range(0, 255)));
      else if (pick < 21) begin
         rule_chars.delete();
         repeat ($urandom_range(1, 8)) rule_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // The four list codes with no terms, and broken or short headers.
   task automatic test_list_codes();
      send_text("AI");
      send_text("AO");
      send_text("DI");
      send_text("DO");
      send_text("XI+pr5");
      send_text("A");
   endtask

   // Value edges, overflow, zero values, leading zeros and a repeated term.
   task automatic test_value_limits();
      send_text("AO+pr255-sp65535+dp1");
      send_text("DI+pr256");
      send_text("DO-sp65536");
      send_text("AI+dp0");
      send_text("AI+pr007-pr6+pr17");
   endtask

   // Address edges, odd separators including the zero and all-ones characters, and the
   // ways an address can be cut short or followed by something that is not a term.
   task automatic test_address_forms();
      send_text("AI+sa255.255.255.255-da0.0.0.1");
      send_text("DO+sa0.0.0.0");
      put_text("AI+da1");
      rule_chars.push_back(8'h00);
      put_text("2");
      rule_chars.push_back(8'hFF);
      put_text("3 4");
      send_rule();
      send_text("AI+sa1.2.3");
      send_text("AI-sa1.2.3.4x");
      send_text("AI+sa1..2.3.4");
   endtask

   // Strings cut off after a sign or inside a type, bad types, and values with no digits.
   task automatic test_malformed_terms();
      send_text("AI+");
      send_text("AI+s");
      send_text("AI+pa5");
      send_text("AI+pr-sp5");
      send_text("AI5");
   endtask

   // The receiver holds off for a long time while rules keep coming, so the pending result
   // blocks the next last character and the input channel stalls.
   task automatic test_input_stall();
      sender_gaps_on = 1'b0;
      long_hold_req  = 1'b1;
      repeat (8) send_text("DO+pr1");
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_rules();
      int words;
      words = 0;
      while (words < RANDOM_WORDS) begin
         // Now and then switch to stretches where one or both sides never pause.
         if ($urandom_range(0, 5) == 0) begin
            sender_gaps_on   = ($urandom_range(0, 2) != 0);
            receiver_gaps_on = ($urandom_range(0, 2) != 0);
         end
         build_random_rule();
         words += rule_chars.size();
         send_rule();
      end
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_list_codes();
      test_value_limits();
      test_address_forms();
      test_malformed_terms();
      test_input_stall();
      test_random_rules();
      req_tvalid <= 1'b0;
      while (expected_rules.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
